>>> src/sdrt_pkg.sv
// Package for the sorted deny-rule table: slot record, codes and sizes.
// Used by sdrt_cell and sorted_deny_rule_table; no dependencies.
`default_nettype none
package sdrt_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REVOKE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_ID   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [63:0] id;
        logic [63:0] institution;
        logic [63:0] target;
        logic [31:0] kind_mask;
        logic        deny;
        logic [63:0] expiry;
        logic [63:0] provenance;
        logic        revoked;
    } slot_t;

    // Per-cell match flags from the compare cycle.
    typedef struct packed {
        logic live;
        logic hit;
        logic above;
        logic deny_match;
    } flags_t;

    // Command from the controller to every cell.
    typedef struct packed {
        logic  compare;
        logic  insert;
        logic  revoke;
        slot_t new_slot;
        logic [63:0] agent;
        logic [4:0]  kind;
        logic [63:0] now;
    } cmd_t;
endpackage
`default_nettype wire

>>> src/sdrt_cell.sv
// One slot of the sorted rule table: holds a rule, compares it to the
// broadcast key and shifts to its upper neighbor on insert. Uses sdrt_pkg.
`default_nettype none
module sdrt_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sdrt_pkg::cmd_t cmd,
    input  wire logic           live,
    input  wire logic           prev_above,
    input  wire sdrt_pkg::slot_t prev_slot,
    output sdrt_pkg::slot_t      slot,
    output sdrt_pkg::flags_t     flags
);
    sdrt_pkg::slot_t  slot_reg;
    sdrt_pkg::flags_t flags_reg;
    sdrt_pkg::flags_t flags_next;
    logic             applies;

    // empty slots count as above the key so the first one takes the new rule
    always_comb
    begin
        applies = !slot_reg.revoked
            && !(slot_reg.expiry != 64'd0 && slot_reg.expiry <= cmd.now)
            && !(slot_reg.target != 64'd0 && slot_reg.target != cmd.agent)
            && slot_reg.kind_mask[cmd.kind];
        flags_next.live = live;
        flags_next.hit = live && slot_reg.id == cmd.new_slot.id;
        flags_next.above = !live || slot_reg.id > cmd.new_slot.id;
        flags_next.deny_match = live && applies && slot_reg.deny;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cmd.compare)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert && flags_reg.above)
        begin
            slot_reg <= prev_above ? prev_slot : cmd.new_slot;
        end
        else if (cmd.revoke && flags_reg.hit)
        begin
            slot_reg.revoked <= 1'b1;
        end
    end

    assign slot = slot_reg;
    assign flags = flags_reg;
endmodule
`default_nettype wire

>>> src/sorted_deny_rule_table.sv
// Sorted deny-rule table top level: handshake, controller, cell chain.
// Depends on sdrt_pkg and sdrt_cell.
//
// Usage: one request transfer on s_axis (tdata fields below) gives exactly
// one response transfer on m_axis. Every cell compares its rule against the
// request in the compare state (S_CMP); in the action state (S_ACT) the chain
// shifts on insert, the hit cell sets its revoked mark, and a priority pick
// over the match flags forms the query answer into the output register. An
// item passes the compare state and then the action state in the cells; the
// response becomes valid as the action state ends. The next request
// is taken only in the cycle after the response transfer.
// Reset empties the table (count zero) and clears the output valid.
// A stalled receiver holds the response; no new request is taken until the
// response is transferred.
`default_nettype none
module sorted_deny_rule_table (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[1:0], rule_id, institution, target_agent, kind_mask, deny_mode,
    // expiry_time, provenance, query_agent, query_kind, now_time
    input  wire logic [487:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], allowed, deny_institution[63:0], zero pad
    output logic [71:0]       m_axis_tdata
);
    localparam int D = sdrt_pkg::TABLE_DEPTH;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_ACT} state_t;

    state_t                       state_reg;
    logic [sdrt_pkg::CNT_W-1:0]   count_reg;
    logic [1:0]                   op_reg;
    sdrt_pkg::cmd_t               cmd_reg;
    sdrt_pkg::cmd_t               cmd;
    logic                         out_valid_reg;
    logic [2:0]                   status_reg;
    logic                         allowed_reg;
    logic [63:0]                  inst_reg;

    sdrt_pkg::slot_t  slots [D];
    sdrt_pkg::flags_t flags [D];
    logic [D-1:0]     hit_vec;
    logic             any_hit;
    logic             first_deny;
    logic [63:0]      deny_inst;
    logic [2:0]       status_next;
    logic             do_ins;

    assign s_axis_tready = state_reg == S_IDLE && !out_valid_reg;

    always_comb
    begin
        cmd = cmd_reg;
        cmd.compare = state_reg == S_CMP;
        cmd.insert = state_reg == S_ACT && do_ins;
        cmd.revoke = state_reg == S_ACT && op_reg == sdrt_pkg::OP_REVOKE;
    end

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            logic [sdrt_pkg::CNT_W-1:0] gi;
            logic live;
            logic prev_above;
            sdrt_pkg::slot_t prev_slot;
            assign gi = sdrt_pkg::CNT_W'(g);
            assign live = gi < count_reg;
            if (g == 0)
            begin : g_first
                assign prev_above = 1'b0;
                assign prev_slot = cmd_reg.new_slot;
            end
            else
            begin : g_rest
                assign prev_above = flags[g-1].above;
                assign prev_slot = slots[g-1];
            end
            sdrt_cell u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd), .live(live),
                .prev_above(prev_above), .prev_slot(prev_slot),
                .slot(slots[g]), .flags(flags[g])
            );
            assign hit_vec[g] = flags[g].hit;
        end
    endgenerate

    // query answer and insert decision: lowest-index matching deny rule, status
    always_comb
    begin
        any_hit = |hit_vec;
        first_deny = 1'b0;
        deny_inst = 64'd0;
        for (int i = D - 1; i >= 0; i--)
        begin
            if (flags[i].deny_match)
            begin
                first_deny = 1'b1;
                deny_inst = slots[i].institution;
            end
        end
        status_next = sdrt_pkg::ST_OK;
        do_ins = 1'b0;
        case (op_reg)
            sdrt_pkg::OP_INSERT:
            begin
                if (cmd_reg.new_slot.id == 64'd0)
                    status_next = sdrt_pkg::ST_ZERO_ID;
                else if (count_reg >= sdrt_pkg::CNT_W'(D))
                    status_next = sdrt_pkg::ST_FULL;
                else if (any_hit)
                    status_next = sdrt_pkg::ST_DUPLICATE;
                else
                    do_ins = 1'b1;
            end
            sdrt_pkg::OP_REVOKE:
            begin
                if (!any_hit)
                    status_next = sdrt_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                status_next = sdrt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    state_reg <= S_IDLE;
                    out_valid_reg <= 1'b1;
                    if (do_ins)
                        count_reg <= count_reg + 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready)
        begin
            op_reg <= s_axis_tdata[1:0];
            cmd_reg.compare <= 1'b0;
            cmd_reg.insert <= 1'b0;
            cmd_reg.revoke <= 1'b0;
            cmd_reg.new_slot.id <= s_axis_tdata[65:2];
            cmd_reg.new_slot.institution <= s_axis_tdata[129:66];
            cmd_reg.new_slot.target <= s_axis_tdata[193:130];
            cmd_reg.new_slot.kind_mask <= s_axis_tdata[225:194];
            cmd_reg.new_slot.deny <= s_axis_tdata[226];
            cmd_reg.new_slot.expiry <= s_axis_tdata[290:227];
            cmd_reg.new_slot.provenance <= (s_axis_tdata[354:291] != 64'd0)
                ? s_axis_tdata[354:291] : s_axis_tdata[65:2];
            cmd_reg.new_slot.revoked <= 1'b0;
            cmd_reg.agent <= s_axis_tdata[418:355];
            cmd_reg.kind <= s_axis_tdata[423:419];
            cmd_reg.now <= s_axis_tdata[487:424];
        end
        if (state_reg == S_ACT)
        begin
            status_reg <= status_next;
            if (op_reg == sdrt_pkg::OP_QUERY && cmd_reg.kind != 5'd0 && first_deny)
            begin
                allowed_reg <= 1'b0;
                inst_reg <= deny_inst;
            end
            else
            begin
                allowed_reg <= 1'b1;
                inst_reg <= 64'd0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {4'd0, inst_reg, allowed_reg, status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sdrt_pkg::CNT_W'(D))
        else $error("rule count exceeds depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_ACT |=> count_reg == $past(count_reg))
        else $error("rule count changed outside action cycle");
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACT |-> $onehot0(hit_vec))
        else $error("duplicate ids in table");
endmodule
`default_nettype wire

>>> tb/tb_sorted_deny_rule_table.sv
// Testbench for sorted_deny_rule_table: directed and random insert, revoke and query
// transfers, checked against a behavioral rule table kept in the testbench.
// Depends on sdrt_pkg and the RTL of sorted_deny_rule_table.
`timescale 1ns / 100ps
`default_nettype none
module tb_sorted_deny_rule_table;
    typedef struct {
        sdrt_pkg::op_t op;
        logic [63:0]   rule_id;
        logic [63:0]   institution;
        logic [63:0]   target;
        logic [31:0]   kind_mask;
        logic          deny;
        logic [63:0]   expiry;
        logic [63:0]   provenance;
        logic [63:0]   agent;
        logic [4:0]    kind;
        logic [63:0]   now;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic        allowed;
        logic [63:0] institution;
    } answer_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [487:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    request_t pending_q[$];
    answer_t  answer_q[$];
    int       phase = 0;
    int       errors = 0;
    int       idle_cycles;

    // behavioral copy of the table
    sdrt_pkg::slot_t rules[sdrt_pkg::TABLE_DEPTH] = '{default: '0};
    int              rule_cnt = 0;

    sorted_deny_rule_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int      pos;
        logic    hit;
        a.status = sdrt_pkg::ST_OK;
        a.allowed = 1'b1;
        a.institution = '0;
        pos = 0;
        hit = 1'b0;
        if (r.op == sdrt_pkg::OP_INSERT || r.op == sdrt_pkg::OP_REVOKE)
        begin
            while (pos < rule_cnt && rules[pos].id < r.rule_id)
                pos++;
            hit = (pos < rule_cnt) && (rules[pos].id == r.rule_id);
        end
        case (r.op)
            sdrt_pkg::OP_INSERT:
            begin
                if (r.rule_id == '0)
                    a.status = sdrt_pkg::ST_ZERO_ID;
                else if (rule_cnt >= sdrt_pkg::TABLE_DEPTH)
                    a.status = sdrt_pkg::ST_FULL;
                else if (hit)
                    a.status = sdrt_pkg::ST_DUPLICATE;
                else
                begin
                    for (int i = rule_cnt; i > pos; i--)
                        rules[i] = rules[i-1];
                    rules[pos].id = r.rule_id;
                    rules[pos].institution = r.institution;
                    rules[pos].target = r.target;
                    rules[pos].kind_mask = r.kind_mask;
                    rules[pos].deny = r.deny;
                    rules[pos].expiry = r.expiry;
                    rules[pos].provenance = (r.provenance != '0) ? r.provenance : r.rule_id;
                    rules[pos].revoked = 1'b0;
                    rule_cnt++;
                end
            end
            sdrt_pkg::OP_REVOKE:
            begin
                if (!hit)
                    a.status = sdrt_pkg::ST_NOT_FOUND;
                else
                    rules[pos].revoked = 1'b1;
            end
            sdrt_pkg::OP_QUERY:
            begin
                if (r.kind != '0)
                begin
                    for (int i = 0; i < rule_cnt; i++)
                    begin
                        if (rules[i].revoked)
                            continue;
                        if (rules[i].expiry != '0 && rules[i].expiry <= r.now)
                            continue;
                        if (rules[i].target != '0 && rules[i].target != r.agent)
                            continue;
                        if (!rules[i].kind_mask[r.kind])
                            continue;
                        if (rules[i].deny)
                        begin
                            a.allowed = 1'b0;
                            a.institution = rules[i].institution;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [487:0] pack_request(request_t r);
        return {r.now, r.kind, r.agent, r.provenance, r.expiry, r.deny,
                r.kind_mask, r.target, r.institution, r.rule_id, r.op};
    endfunction

    function automatic request_t make_request(sdrt_pkg::op_t op, logic [63:0] id);
        request_t r;
        int       sel;
        r.op = op;
        r.rule_id = id;
        r.institution = rand64();
        sel = $urandom_range(0, 9);
        r.target = (sel < 5) ? 64'd0 : (sel < 9) ? 64'($urandom_range(1, 3)) : rand64();
        sel = $urandom_range(0, 9);
        r.kind_mask = (sel == 0) ? 32'hFFFF_FFFF : (sel == 1) ? 32'h0 : $urandom;
        r.deny = $urandom_range(0, 3) != 0;
        sel = $urandom_range(0, 9);
        r.expiry = (sel < 5) ? 64'd0 : (sel < 9) ? 64'($urandom_range(1, 200)) : rand64();
        r.provenance = $urandom_range(0, 1) ? 64'd0 : rand64();
        sel = $urandom_range(0, 9);
        r.agent = (sel < 8) ? 64'($urandom_range(1, 3)) : rand64();
        r.kind = 5'($urandom_range(0, 31));
        sel = $urandom_range(0, 9);
        r.now = (sel < 8) ? 64'($urandom_range(0, 220)) : rand64();
        return r;
    endfunction

    function automatic request_t random_request();
        int            sel;
        sdrt_pkg::op_t op;
        logic [63:0]   id;
        sel = $urandom_range(0, 99);
        op = (sel < 15) ? sdrt_pkg::OP_INSERT : (sel < 35) ? sdrt_pkg::OP_REVOKE :
             (sel < 95) ? sdrt_pkg::OP_QUERY : sdrt_pkg::OP_NONE;
        sel = $urandom_range(0, 19);
        id = (sel == 0) ? 64'd0 : (sel == 1) ? rand64() : 64'($urandom_range(1, 40));
        return make_request(op, id);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_q.size() > 0 &&
                !((phase == 1 && $urandom_range(0, 99) < 63) ||
                  (phase == 3 && $urandom_range(0, 99) < 12)))
            begin
                request_t r;
                r = pending_q.pop_front();
                answer_q.push_back(apply_request(r));
                s_axis_tdata <= pack_request(r);
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !((phase == 2 && $urandom_range(0, 99) < 63) ||
                               (phase == 3 && $urandom_range(0, 99) < 12));
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                answer_t a;
                a = answer_q.pop_front();
                if (m_axis_tdata[2:0] !== a.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, a.status,
                             m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[3] !== a.allowed)
                begin
                    $display("%0t: allowed expected %0d actual %0d", $time, a.allowed,
                             m_axis_tdata[3]);
                    errors++;
                end
                if (m_axis_tdata[67:4] !== a.institution)
                begin
                    $display("%0t: institution expected %h actual %h", $time,
                             a.institution, m_axis_tdata[67:4]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("tb_sorted_deny_rule_table failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || s_axis_tvalid || answer_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        request_t r;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        pending_q.push_back(make_request(sdrt_pkg::OP_QUERY, 64'd0));
        pending_q.push_back(make_request(sdrt_pkg::OP_INSERT, 64'd0));
        pending_q.push_back(make_request(sdrt_pkg::OP_REVOKE, 64'd0));
        pending_q.push_back(make_request(sdrt_pkg::OP_REVOKE, 64'd7));
        r = make_request(sdrt_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        r.target = '0; r.kind_mask = 32'hFFFF_FFFF; r.deny = 1'b1; r.expiry = '0;
        r.institution = 64'hFFFF_FFFF_FFFF_FFFF;
        pending_q.push_back(r);
        r = make_request(sdrt_pkg::OP_INSERT, 64'd5);
        r.target = 64'd2; r.kind_mask = 32'h8000_0002; r.deny = 1'b1; r.expiry = 64'd100;
        pending_q.push_back(r);
        r = make_request(sdrt_pkg::OP_INSERT, 64'd3);
        r.target = '0; r.kind_mask = 32'hFFFF_FFFF; r.deny = 1'b0; r.expiry = '0;
        pending_q.push_back(r);
        pending_q.push_back(make_request(sdrt_pkg::OP_INSERT, 64'd5));
        for (int k = 0; k < 6; k++)
        begin
            r = make_request(sdrt_pkg::OP_QUERY, 64'd0);
            r.agent = (k < 3) ? 64'd2 : 64'd9;
            r.kind = (k % 3 == 0) ? 5'd31 : (k % 3 == 1) ? 5'd1 : 5'd0;
            r.now = (k == 1) ? 64'd100 : 64'd99;
            pending_q.push_back(r);
        end
        pending_q.push_back(make_request(sdrt_pkg::OP_REVOKE, 64'd5));
        pending_q.push_back(make_request(sdrt_pkg::OP_REVOKE, 64'd5));
        r = make_request(sdrt_pkg::OP_QUERY, 64'd0);
        r.agent = 64'd2; r.kind = 5'd31; r.now = 64'hFFFF_FFFF_FFFF_FFFE;
        pending_q.push_back(r);
        pending_q.push_back(make_request(sdrt_pkg::OP_NONE, rand64()));
        for (int k = 0; k < 20; k++)
            pending_q.push_back(make_request(sdrt_pkg::OP_INSERT, 64'd100 + k));
        drain();

        for (int p = 0; p < 4; p++)
        begin
            phase = p;
            for (int k = 0; k < 228; k++)
                pending_q.push_back(random_request());
            drain();
        end
        phase = 0;
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_sorted_deny_rule_table passed");
        else
            $display("tb_sorted_deny_rule_table failed");
        $finish;
    end
endmodule
`default_nettype wire
